@@ sv/pps_pkg.sv @@
// shared types and constants for the preemptive priority scheduler
package pps_pkg;

   localparam int MAX_PROCS = 16;
   localparam int IDX_W = $clog2(MAX_PROCS);
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int TIME_W = 21;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);

   typedef struct packed {
      logic [15:0] arrival_time;
      logic [15:0] burst_time;
      logic [7:0]  priority_req;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [5:0]        process_index;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] finish_time;
      logic [TIME_W-1:0] turnaround_time;
      logic [TIME_W-1:0] waiting_time;
      logic              last_result;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DECIDE,
      ST_REPORT,
      ST_EMIT
   } state_type;

endpackage

@@ sv/pps_front.sv @@
// input queue: takes items and normalises zero bursts
module pps_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  pps_pkg::req_type req_data,
   output logic             q_valid,
   input  logic             q_take,
   output pps_pkg::req_type q_data
);

   pps_pkg::req_type mem [pps_pkg::FIFO_DEPTH];
   logic [pps_pkg::FIFO_AW:0] wr_ff, wr_in, rd_ff, rd_in;
   pps_pkg::req_type norm;

   always_comb begin
      norm = req_data;
      if (req_data.burst_time == 16'd0) begin
         norm.burst_time = 16'd1;
      end
   end

   assign full = (wr_ff[pps_pkg::FIFO_AW] != rd_ff[pps_pkg::FIFO_AW]) &&
                 (wr_ff[pps_pkg::FIFO_AW-1:0] == rd_ff[pps_pkg::FIFO_AW-1:0]);
   assign q_valid = wr_ff != rd_ff;
   assign q_data = mem[rd_ff[pps_pkg::FIFO_AW-1:0]];
   assign wr_in = wr_ff + ((push && !full) ? 1'b1 : 1'b0);
   assign rd_in = rd_ff + ((q_take && q_valid) ? 1'b1 : 1'b0);

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem[wr_ff[pps_pkg::FIFO_AW-1:0]] <= norm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

endmodule

@@ sv/pps_back.sv @@
// process tables, scheduling sequencer and output register
module pps_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_take,
   input  pps_pkg::req_type q_data,
   output logic             empty,
   input  logic             pop,
   output pps_pkg::rsp_type rsp_data
);

   localparam int IW = pps_pkg::IDX_W;
   localparam int CW = pps_pkg::CNT_W;
   localparam int TW = pps_pkg::TIME_W;

   logic [15:0]   arr_ff [pps_pkg::MAX_PROCS];
   logic [15:0]   bur_ff [pps_pkg::MAX_PROCS];
   logic [7:0]    pri_ff [pps_pkg::MAX_PROCS];
   logic [15:0]   rem_ff [pps_pkg::MAX_PROCS];
   logic [TW-1:0] sta_ff [pps_pkg::MAX_PROCS];
   logic [TW-1:0] fin_ff [pps_pkg::MAX_PROCS];
   logic [pps_pkg::MAX_PROCS-1:0] started_ff;

   pps_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] done_ff, done_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [TW-1:0] time_ff, time_in;
   logic          found_ff, found_in;
   logic [IW-1:0] pick_ff, pick_in;
   logic [7:0]    best_ff, best_in;
   logic [16:0]   next_ff, next_in;
   logic          full_ff, full_in;
   pps_pkg::rsp_type out_ff, out_in;

   logic [IW-1:0] ix;
   logic          load_en, run_en, rep_en;
   logic [TW-1:0] turn;

   assign ix = idx_ff[IW-1:0];
   assign empty = !full_ff;
   assign rsp_data = out_ff;
   assign turn = fin_ff[ix] - TW'(arr_ff[ix]);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      done_in = done_ff;
      idx_in = idx_ff;
      time_in = time_ff;
      found_in = found_ff;
      pick_in = pick_ff;
      best_in = best_ff;
      next_in = next_ff;
      full_in = full_ff;
      out_in = out_ff;
      q_take = 1'b0;
      load_en = 1'b0;
      run_en = 1'b0;
      rep_en = 1'b0;
      if (pop && full_ff) begin
         full_in = 1'b0;
      end
      case (state_ff)
         pps_pkg::ST_LOAD: begin
            if (q_valid) begin
               q_take = 1'b1;
               if (cnt_ff < CW'(pps_pkg::MAX_PROCS)) begin
                  load_en = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
               if (q_data.last) begin
                  time_in = '0;
                  done_in = '0;
                  idx_in = '0;
                  found_in = 1'b0;
                  next_in = '1;
                  state_in = pps_pkg::ST_SCAN;
               end
            end
         end
         pps_pkg::ST_SCAN: begin
            if (idx_ff == cnt_ff) begin
               state_in = pps_pkg::ST_DECIDE;
            end else begin
               if (rem_ff[ix] != 16'd0) begin
                  if (TW'(arr_ff[ix]) <= time_ff) begin
                     if (!found_ff || pri_ff[ix] < best_ff) begin
                        found_in = 1'b1;
                        best_in = pri_ff[ix];
                        pick_in = ix;
                     end
                  end else if ({1'b0, arr_ff[ix]} < next_ff) begin
                     next_in = {1'b0, arr_ff[ix]};
                  end
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         pps_pkg::ST_DECIDE: begin
            idx_in = '0;
            found_in = 1'b0;
            next_in = '1;
            state_in = pps_pkg::ST_SCAN;
            if (done_ff == cnt_ff) begin
               state_in = pps_pkg::ST_REPORT;
            end else if (!found_ff) begin
               time_in = TW'(next_ff[15:0]);
            end else begin
               run_en = 1'b1;
               time_in = time_ff + 1'b1;
               if (rem_ff[pick_ff] == 16'd1) begin
                  done_in = done_ff + 1'b1;
                  if (done_ff + 1'b1 == cnt_ff) begin
                     state_in = pps_pkg::ST_REPORT;
                  end
               end
            end
         end
         pps_pkg::ST_REPORT: begin
            if (idx_ff == cnt_ff) begin
               cnt_in = '0;
               state_in = pps_pkg::ST_LOAD;
            end else if (!full_ff || pop) begin
               out_in.process_index = 6'(idx_ff);
               out_in.start_time = sta_ff[ix];
               out_in.finish_time = fin_ff[ix];
               out_in.turnaround_time = turn;
               out_in.waiting_time = (turn > TW'(bur_ff[ix])) ?
                                     turn - TW'(bur_ff[ix]) : '0;
               out_in.last_result = (idx_ff + 1'b1 == cnt_ff);
               full_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = pps_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         arr_ff[cnt_ff[IW-1:0]] <= q_data.arrival_time;
         bur_ff[cnt_ff[IW-1:0]] <= q_data.burst_time;
         rem_ff[cnt_ff[IW-1:0]] <= q_data.burst_time;
         pri_ff[cnt_ff[IW-1:0]] <= q_data.priority_req;
      end
      if (run_en) begin
         rem_ff[pick_ff] <= rem_ff[pick_ff] - 16'd1;
         if (!started_ff[pick_ff]) begin
            sta_ff[pick_ff] <= time_ff;
         end
         if (rem_ff[pick_ff] == 16'd1) begin
            fin_ff[pick_ff] <= time_ff + 1'b1;
         end
      end
      out_ff <= out_in;
      found_ff <= found_in;
      pick_ff <= pick_in;
      best_ff <= best_in;
      next_ff <= next_in;
      time_ff <= time_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pps_pkg::ST_LOAD;
         cnt_ff <= '0;
         done_ff <= '0;
         idx_ff <= '0;
         full_ff <= 1'b0;
         started_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         done_ff <= done_in;
         idx_ff <= idx_in;
         full_ff <= full_in;
         if (load_en) begin
            started_ff[cnt_ff[IW-1:0]] <= 1'b0;
         end
         if (run_en) begin
            started_ff[pick_ff] <= 1'b1;
         end
      end
   end

endmodule

@@ sv/preemptive_priority_scheduler.sv @@
// top level of the preemptive priority scheduler
//  channel   ports                     direction
//  request   push, full, req_data      in
//  response  pop, empty, rsp_data      out
// loading takes one cycle per item through a four-entry input queue, while the block is not scheduling or reporting.
// one simulated time unit is a scan over the n loaded processes followed by a decision;
// idle stretches are skipped in one step. reporting takes one cycle per result.
// synchronous active-high reset empties both queues; pop held low stalls reporting.
module preemptive_priority_scheduler (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  pps_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output pps_pkg::rsp_type rsp_data
);

   logic             q_valid;
   logic             q_take;
   pps_pkg::req_type q_data;

   pps_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .req_data(req_data),
      .q_valid (q_valid),
      .q_take  (q_take),
      .q_data  (q_data)
   );

   pps_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_take  (q_take),
      .q_data  (q_data),
      .empty   (empty),
      .pop     (pop),
      .rsp_data(rsp_data)
   );

   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid) else $error("queue read while empty");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("result changed while waiting");

endmodule

@@ tb/pps_checker.sv @@
// checker for the preemptive priority scheduler: predicts schedules and compares results
module pps_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             full,
   input  pps_pkg::req_type req_data,
   input  logic             empty,
   input  logic             pop,
   input  pps_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   int unsigned      arrival_q[pps_pkg::MAX_PROCS];
   int unsigned      burst_q[pps_pkg::MAX_PROCS];
   int unsigned      prio_q[pps_pkg::MAX_PROCS];
   int unsigned      left_q[pps_pkg::MAX_PROCS];
   int unsigned      start_q[pps_pkg::MAX_PROCS];
   int unsigned      finish_q[pps_pkg::MAX_PROCS];
   bit               began_q[pps_pkg::MAX_PROCS];
   int               held_count;
   pps_pkg::rsp_type sched_results[$];

   assign pending_count = sched_results.size();

   task automatic load_process(input pps_pkg::req_type item);
      int unsigned b;
      if (held_count < pps_pkg::MAX_PROCS) begin
         b = (item.burst_time == 0) ? 1 : item.burst_time;
         arrival_q[held_count] = item.arrival_time;
         burst_q[held_count] = b;
         left_q[held_count] = b;
         prio_q[held_count] = item.priority_req;
         began_q[held_count] = 0;
         held_count++;
      end
   endtask

   task automatic run_schedule();
      int unsigned      now, pick, best, next_arr, turn, wait_t;
      int               done;
      bit               found;
      pps_pkg::rsp_type r;
      now = 0;
      done = 0;
      while (done < held_count) begin
         found = 0;
         pick = 0;
         best = 0;
         next_arr = 32'hFFFF_FFFF;
         for (int i = 0; i < held_count; i++) begin
            if (left_q[i] != 0) begin
               if (arrival_q[i] <= now) begin
                  if (!found || prio_q[i] < best) begin
                     found = 1;
                     best = prio_q[i];
                     pick = i;
                  end
               end else if (arrival_q[i] < next_arr) begin
                  next_arr = arrival_q[i];
               end
            end
         end
         if (!found) begin
            now = next_arr;
         end else begin
            if (!began_q[pick]) begin
               began_q[pick] = 1;
               start_q[pick] = now;
            end
            left_q[pick]--;
            now++;
            if (left_q[pick] == 0) begin
               finish_q[pick] = now;
               done++;
            end
         end
      end
      for (int i = 0; i < held_count; i++) begin
         turn = finish_q[i] - arrival_q[i];
         wait_t = (turn > burst_q[i]) ? turn - burst_q[i] : 0;
         r.process_index = i[5:0];
         r.start_time = start_q[i][pps_pkg::TIME_W-1:0];
         r.finish_time = finish_q[i][pps_pkg::TIME_W-1:0];
         r.turnaround_time = turn[pps_pkg::TIME_W-1:0];
         r.waiting_time = wait_t[pps_pkg::TIME_W-1:0];
         r.last_result = (i + 1 == held_count);
         sched_results.push_back(r);
      end
      held_count = 0;
   endtask

   task automatic compare_result(input pps_pkg::rsp_type got);
      pps_pkg::rsp_type want;
      if (sched_results.size() == 0) begin
         $error("unexpected result item, index %0d", got.process_index);
         fail_count++;
      end else begin
         want = sched_results.pop_front();
         if (got.process_index !== want.process_index) begin
            $error("process_index expected %0d got %0d", want.process_index,
                   got.process_index);
            fail_count++;
         end
         if (got.start_time !== want.start_time) begin
            $error("start_time expected %0d got %0d", want.start_time, got.start_time);
            fail_count++;
         end
         if (got.finish_time !== want.finish_time) begin
            $error("finish_time expected %0d got %0d", want.finish_time, got.finish_time);
            fail_count++;
         end
         if (got.turnaround_time !== want.turnaround_time) begin
            $error("turnaround_time expected %0d got %0d", want.turnaround_time,
                   got.turnaround_time);
            fail_count++;
         end
         if (got.waiting_time !== want.waiting_time) begin
            $error("waiting_time expected %0d got %0d", want.waiting_time,
                   got.waiting_time);
            fail_count++;
         end
         if (got.last_result !== want.last_result) begin
            $error("last_result expected %0d got %0d", want.last_result,
                   got.last_result);
            fail_count++;
         end
      end
   endtask

   initial begin
      fail_count = 0;
      held_count = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty)
            compare_result(rsp_data);
         if (push && !full) begin
            load_process(req_data);
            if (req_data.last)
               run_schedule();
         end
      end
   end

endmodule

@@ tb/tb_preemptive_priority_scheduler.sv @@
// testbench top for the preemptive priority scheduler: stimulus, receiver and verdict
module tb_preemptive_priority_scheduler;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock;
   logic             reset;
   logic             push;
   logic             full;
   pps_pkg::req_type req_data;
   logic             empty;
   logic             pop;
   pps_pkg::rsp_type rsp_data;
   int               fail_count;
   int               pending_count;
   int               sent;

   preemptive_priority_scheduler i_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   pps_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_data      (req_data),
      .empty         (empty),
      .pop           (pop),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 95)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   task automatic send_process(input logic [15:0] arr, input logic [15:0] bur,
                               input logic [7:0] prio, input logic lst);
      int gap;
      req_data <= '{arrival_time: arr, burst_time: bur, priority_req: prio, last: lst};
      push <= 1;
      do @(posedge clock); while (full);
      sent++;
      gap = (sent % 50 < 10) ? 0 : pick_gap();
      if (gap > 0) begin
         push <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_batch(input int n, input bit wide_arrivals);
      logic [15:0] a, b;
      for (int i = 0; i < n; i++) begin
         a = wide_arrivals ? 16'($urandom) : 16'($urandom_range(0, 40));
         b = ($urandom_range(0, 31) == 0) ? 16'($urandom_range(0, 127))
                                          : 16'($urandom_range(0, 12));
         send_process(a, b, 8'($urandom), i == n - 1);
      end
   endtask

   task automatic drain_results();
      push <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // receiver: random stalls, one long hold-off to fill the block
   initial begin
      int got;
      int gap;
      bit held;
      got = 0;
      held = 0;
      pop = 0;
      forever begin
         @(posedge clock);
         if (pop && !empty)
            got++;
         if (!held && got >= 40) begin
            held = 1;
            pop <= 0;
            repeat (600) @(posedge clock);
            pop <= 1;
         end else begin
            gap = ((got / 30) % 3 == 0) ? 0 : pick_gap();
            if (gap > 0) begin
               pop <= 0;
               repeat (gap) @(posedge clock);
            end
            pop <= 1;
         end
      end
   end

   initial begin
      reset = 1;
      push = 0;
      req_data = '0;
      sent = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // one long process arriving late at the widest values
      send_process(16'hFFFF, 16'hFFFF, 8'hFF, 1);
      // zero burst
      send_process(16'h0000, 16'h0000, 8'h00, 1);
      // preemption, ties and an idle stretch
      send_process(16'd0, 16'd5, 8'd10, 0);
      send_process(16'd2, 16'd3, 8'd1, 0);
      send_process(16'd2, 16'd2, 8'd1, 0);
      send_process(16'd30, 16'd0, 8'd10, 0);
      send_process(16'd0, 16'd4, 8'd200, 1);
      // table overflow with the last marker on a dropped item
      for (int i = 0; i < pps_pkg::MAX_PROCS + 2; i++)
         send_process(16'(i), 16'(i % 4), 8'(i % 3), i == pps_pkg::MAX_PROCS + 1);

      drain_results();

      while (sent < 330) begin
         if ($urandom_range(0, 9) == 0)
            send_batch($urandom_range(pps_pkg::MAX_PROCS + 1, pps_pkg::MAX_PROCS + 3), 0);
         else
            send_batch($urandom_range(1, pps_pkg::MAX_PROCS), $urandom_range(0, 7) == 0);
         if ($urandom_range(0, 7) == 0)
            drain_results();
      end

      push <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("preemptive_priority_scheduler verification clean");
      else
         $display("preemptive_priority_scheduler verification failed");
      $finish;
   end

   initial begin
      #40ms;
      $display("preemptive_priority_scheduler verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
sv/pps_pkg.sv
sv/pps_front.sv
sv/pps_back.sv
sv/preemptive_priority_scheduler.sv
tb/pps_checker.sv
tb/tb_preemptive_priority_scheduler.sv
